### rtl/core/bipartition_tripartition_scorer_top_macros.svh
// ----------------------------------------------------------------------------
// bipartition tripartition scorer assertion macros
// shared concurrent assertion forms for the scorer rtl
// ----------------------------------------------------------------------------
`ifndef BIPARTITION_TRIPARTITION_SCORER_TOP_MACROS_SVH
`define BIPARTITION_TRIPARTITION_SCORER_TOP_MACROS_SVH

// clocked assertion, off while in reset
`define BTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion, also checked during reset
`define BTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/bts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// types and constants of the bipartition tripartition scorer
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int unsigned MASK_BITS = 64;
  localparam int unsigned SUM_BITS  = 26;

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    K_ADD   = 1'b0,
    K_SCORE = 1'b1
  } kind_e;

endpackage

### rtl/core/bipartition_tripartition_scorer_top.sv
`timescale 1ns / 1ps
// order: a score item reads every table entry before its strobe; an add stops at its first
//   matching entry, and an add with an empty side goes straight from idle to the strobe
// throughput: one item at a time, the next accepted the cycle after the strobe;
//   the rate is set by the single-port table read, one entry per cycle
// reset: asynchronous active low, clears the entry count and sequencer; table contents
//   stay undefined and get no clearing pass; the receiver cannot stall
// ----------------------------------------------------------------------------
// bipartition tripartition scorer
// weighted bipartition table with add and tripartition score sequencer
// ----------------------------------------------------------------------------
`include "bipartition_tripartition_scorer_top_macros.svh"

module bipartition_tripartition_scorer_top
  import bts_pkg::*;
#(
  parameter int unsigned TAXA        = 64,
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    kind_i,
  input  logic [MASK_BITS-1:0]    first_mask_i,
  input  logic [MASK_BITS-1:0]    second_mask_i,
  output logic                    result_valid_o,
  output logic [SUM_BITS-1:0]     total_weight_sum_o,
  output logic [1:0]              status_o
);

  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENTRY_W = 2 * TAXA + WEIGHT_BITS;
  localparam int unsigned ACC_W   = ((SUM_BITS > WEIGHT_BITS) ? SUM_BITS : WEIGHT_BITS) + 1;

  function automatic logic side_fits(logic [TAXA-1:0] inner, logic [TAXA-1:0] other,
                                     logic [TAXA-1:0] here, logic [TAXA-1:0] there);
    side_fits = ((inner & ~here) == '0) && ((other & here) == '0) && ((other & there) != '0);
  endfunction

  state_e                 state_q, state_d;
  kind_e                  kind_q, kind_d;
  logic [TAXA-1:0]        a_q, a_d, b_q, b_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]       rd_idx_q;
  logic [ENTRY_W-1:0]     rd_data_q;
  logic [SUM_BITS-1:0]    sum_q, sum_d;
  status_e                status_q, status_d;

  logic                   rd_en;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [ENTRY_W-1:0]     wr_data;

  logic [TAXA-1:0]        in_a, in_b;
  logic [TAXA-1:0]        ent_p, ent_q;
  logic [WEIGHT_BITS-1:0] ent_w, ent_w_inc;
  logic                   hit, same;
  logic [ACC_W-1:0]       acc;
  logic [SUM_BITS-1:0]    acc_sat;
  logic                   score_done;

  logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];

  assign in_a = first_mask_i[TAXA-1:0];
  assign in_b = second_mask_i[TAXA-1:0];

  assign ent_p = rd_data_q[ENTRY_W-1 -: TAXA];
  assign ent_q = rd_data_q[WEIGHT_BITS +: TAXA];
  assign ent_w = rd_data_q[WEIGHT_BITS-1:0];

  assign hit = side_fits(ent_p, ent_q, a_q, b_q) || side_fits(ent_p, ent_q, b_q, a_q) ||
               side_fits(ent_q, ent_p, a_q, b_q) || side_fits(ent_q, ent_p, b_q, a_q);
  assign same = ((ent_p == a_q) && (ent_q == b_q)) || ((ent_p == b_q) && (ent_q == a_q));

  assign ent_w_inc = (ent_w == '1) ? ent_w : ent_w + 1'b1;
  assign acc       = ACC_W'(sum_q) + ACC_W'(ent_w);
  assign acc_sat   = (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : acc[SUM_BITS-1:0];

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    a_d      = a_q;
    b_d      = b_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    rd_vld_d = 1'b0;
    sum_d    = sum_q;
    status_d = status_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = rd_idx_q;
    wr_data  = rd_data_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d   = kind_e'(kind_i);
          a_d      = in_a;
          b_d      = in_b;
          idx_d    = '0;
          sum_d    = '0;
          status_d = ST_OK;
          if ((kind_e'(kind_i) == K_ADD) && ((in_a == '0) || (in_b == '0))) begin
            status_d = ST_EMPTY;
            state_d  = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_q < cnt_q) begin
          rd_en    = 1'b1;
          idx_d    = idx_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          if (kind_q == K_SCORE) begin
            if (hit) begin
              sum_d = acc_sat;
            end
          end else if (same) begin
            wr_en    = 1'b1;
            wr_addr  = rd_idx_q;
            wr_data  = {ent_p, ent_q, ent_w_inc};
            rd_vld_d = 1'b0;
            state_d  = S_DONE;
          end
        end else if (idx_q >= cnt_q) begin
          if (kind_q == K_ADD) begin
            if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = cnt_q[IDX_W-1:0];
              wr_data = {a_q, b_q, WEIGHT_BITS'(1)};
              cnt_d   = cnt_q + 1'b1;
            end
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    a_q      <= a_d;
    b_q      <= b_d;
    idx_q    <= idx_d;
    sum_q    <= sum_d;
    status_q <= status_d;
  end

  // entry table
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[idx_q[IDX_W-1:0]];
      rd_idx_q  <= idx_q[IDX_W-1:0];
    end
  end

  assign busy               = (state_q != S_IDLE);
  assign result_valid_o     = (state_q == S_DONE);
  assign total_weight_sum_o = sum_q;
  assign status_o           = status_q;

  assign score_done = result_valid_o && (kind_q == K_SCORE);

  `BTS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
  `BTS_ASSERT(a_cnt_step, (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + 1'b1), "count jump")
  `BTS_ASSERT(a_strobe_idle, result_valid_o |=> !busy, "strobe not followed by idle")
  `BTS_ASSERT(a_score_ok, score_done |-> (status_q == ST_OK), "score item with bad status")
  `BTS_ASSERT(a_no_read_idle, !busy |-> !rd_en && !wr_en, "table access while idle")

endmodule
